// ===== src/pk7u_pkg.sv =====
// ----------------------------------------------------------------------------
// pk7u_pkg
// Shared types and constants for the streaming padding checker.
// ----------------------------------------------------------------------------
package pk7u_pkg;

    localparam int BLK_W     = 6;   // block_bytes register width
    localparam int CAP_W     = 32;  // out_capacity register width
    localparam int CFG_IDX_W = 1;   // register index width

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 1'd1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_PAD   = 2'd1;
    localparam logic [1:0] STAT_TOO_SMALL = 2'd2;

    localparam logic [BLK_W-1:0] BLK_RESET = 6'd16;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_data;
        logic [1:0]  status;
        logic [31:0] out_length;
        logic        out_last;
    } out_t;

    // Operations on the byte window
    typedef struct packed {
        logic push;   // write at tail, count up
        logic pop;    // advance head, count down
        logic rd_en;  // registered read at head + offset
        logic clear;  // drop all held bytes
    } win_ctrl_t;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_DRAIN,
        FS_PRE,
        FS_CMP,
        FS_EVAL,
        FS_EMIT,
        FS_READ,
        FS_OUT,
        FS_STATUS
    } fsm_t;

endpackage

// ===== src/pk7u_window.sv =====
// ----------------------------------------------------------------------------
// pk7u_window
// Circular byte window held in a synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module pk7u_window #(
    parameter int MAX_BLOCK = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pk7u_pkg::win_ctrl_t              ctrl,
    input  logic [7:0]                       wr_byte,
    input  logic [$clog2(MAX_BLOCK+1)-1:0]   rd_off,
    output logic [$clog2(MAX_BLOCK+1)-1:0]   count,
    output logic [7:0]                       rd_data
);
    import pk7u_pkg::*;

    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SW = CW + 1;

    logic [7:0]    mem [MAX_BLOCK];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] wr_addr, rd_addr;

    // head + offset, folded back into the ring
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(MAX_BLOCK)) begin
            s = s - SW'(MAX_BLOCK);
        end
        return s[AW-1:0];
    endfunction

    assign wr_addr = wrap_add(head_reg, count_reg);
    assign rd_addr = wrap_add(head_reg, rd_off);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.push) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.pop) begin
            head_next  = wrap_add(head_reg, CW'(1));
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_addr] <= wr_byte;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign count   = count_reg;
    assign rd_data = rd_data_reg;

endmodule

// ===== src/pkcs7_unpad_checker_core.sv =====
// ----------------------------------------------------------------------------
// pkcs7_unpad_checker_core
// Streaming padding checker: passes data bytes on and closes each message
// with one status transaction, carrying the unpadded length when the padding checks out.
// ----------------------------------------------------------------------------
//  channel | ports                      | carries
//  --------+----------------------------+-------------------------------------
//  input   | s_valid s_ready s_data     | in_byte, in_last
//  result  | m_valid m_ready m_data     | out_byte is_data status length last
//  config  | cfg_we cfg_addr cfg_wdata  | block_bytes (0), out_capacity (1)
//
//  A byte that is not last is accepted, then passes the drain check; each
//  byte it pushes out of the window adds a memory read, a present step and
//  another drain check. A clean last byte passes accept, drain check, pad
//  pre-check, one compare step per held pad byte, evaluate and emit check;
//  each byte released (window surplus or payload) adds a read and a present
//  step, and the status closes the message; a failed check jumps straight
//  to the status. The window has a single, registered memory read port.
//  Reset is synchronous, active low; the window memory itself is not cleared.
//  A stalled result holds the FSM in the presenting or status state only
//  when the output register is still full.
// ----------------------------------------------------------------------------
module pkcs7_unpad_checker_core #(
    parameter int MAX_BLOCK = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  pk7u_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output pk7u_pkg::out_t                     m_data,
    input  logic                               cfg_we,
    input  logic [pk7u_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pk7u_pkg::CAP_W-1:0]         cfg_wdata
);
    import pk7u_pkg::*;

    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    // Configuration
    logic [BLK_W-1:0] blk_reg;
    logic [CAP_W-1:0] cap_reg;

    // Control state
    fsm_t             state_reg, state_next;
    logic [AW-1:0]    phase_reg, phase_next;
    logic [31:0]      total_reg, total_next;
    logic             m_valid_reg, m_valid_next;

    // Per-message working registers
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             ovf_reg, ovf_next;
    logic             phz_reg, phz_next;
    logic             emode_reg, emode_next;
    logic [CW-1:0]    chk_reg, chk_next;
    logic [CW-1:0]    left_reg, left_next;
    logic [1:0]       st_reg, st_next;
    logic [31:0]      len_reg, len_next;
    out_t             m_data_reg, m_data_next;

    // Window
    win_ctrl_t        win_ctrl;
    logic [CW-1:0]    rd_off;
    logic [CW-1:0]    win_count;
    logic [7:0]       win_rd_data;

    // Derived values
    logic [CW-1:0]    eff_b;
    logic [CW-1:0]    ph_plus;
    logic [AW-1:0]    ph_new;
    logic [8:0]       chk_wide;
    logic [CW-1:0]    chk_start;
    logic             bad_pre;
    logic [31:0]      unpadded;
    logic             out_free;

    pk7u_window #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .wr_byte (byte_next),
        .rd_off  (rd_off),
        .count   (win_count),
        .rd_data (win_rd_data)
    );

    // Block size zero acts as one; anything above the window acts as the window
    always_comb begin
        if (blk_reg == '0) begin
            eff_b = CW'(1);
        end else if (int'(blk_reg) > MAX_BLOCK) begin
            eff_b = CW'(MAX_BLOCK);
        end else begin
            eff_b = CW'(blk_reg);
        end
    end

    // Message length modulo block size, wrapping on the current size
    assign ph_plus = CW'(phase_reg) + CW'(1);
    assign ph_new  = (ph_plus >= eff_b) ? '0 : ph_plus[AW-1:0];

    // First pad byte offset from the head, once the window has drained
    assign chk_wide  = 9'(win_count) + 9'd1 - {1'b0, byte_reg};
    assign chk_start = chk_wide[CW-1:0];

    assign bad_pre = !phz_reg || (byte_reg == 8'd0)
                     || ({1'b0, byte_reg} > 9'(eff_b))
                     || ({1'b0, byte_reg} > 9'(win_count) + 9'd1);

    assign unpadded = total_reg - 32'(byte_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        total_next   = total_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        phz_next     = phz_reg;
        emode_next   = emode_reg;
        chk_next     = chk_reg;
        left_next    = left_reg;
        st_next      = st_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        win_ctrl     = '0;
        rd_off       = '0;

        case (state_reg)
            FS_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data.in_byte;
                    last_next = s_data.in_last;
                    ovf_next  = (total_reg == '1);
                    if (total_reg != '1) begin
                        total_next = total_reg + 32'd1;
                    end
                    if (!s_data.in_last) begin
                        phase_next    = ph_new;
                        win_ctrl.push = 1'b1;
                    end else begin
                        phz_next = (ph_new == '0);
                    end
                    state_next = FS_DRAIN;
                end
            end

            // Release bytes that can no longer fall in the final block.
            // The push landed an edge earlier, so the read sees it.
            FS_DRAIN: begin
                if (win_count >= eff_b) begin
                    win_ctrl.rd_en = 1'b1;
                    emode_next     = 1'b0;
                    state_next     = FS_READ;
                end else if (!last_reg) begin
                    state_next = FS_IDLE;
                end else if (ovf_reg) begin
                    st_next    = STAT_TOO_SMALL;
                    len_next   = '1;
                    state_next = FS_STATUS;
                end else begin
                    state_next = FS_PRE;
                end
            end

            FS_PRE: begin
                if (bad_pre) begin
                    st_next    = STAT_BAD_PAD;
                    len_next   = '0;
                    state_next = FS_STATUS;
                end else if (chk_start == win_count) begin
                    state_next = FS_EVAL;
                end else begin
                    win_ctrl.rd_en = 1'b1;
                    rd_off         = chk_start;
                    chk_next       = chk_start + CW'(1);
                    state_next     = FS_CMP;
                end
            end

            // Compare one held pad byte per cycle, reads issued back to back
            FS_CMP: begin
                if (win_rd_data != byte_reg) begin
                    st_next    = STAT_BAD_PAD;
                    len_next   = '0;
                    state_next = FS_STATUS;
                end else if (chk_reg == win_count) begin
                    state_next = FS_EVAL;
                end else begin
                    win_ctrl.rd_en = 1'b1;
                    rd_off         = chk_reg;
                    chk_next       = chk_reg + CW'(1);
                end
            end

            FS_EVAL: begin
                len_next = unpadded;
                if (unpadded > cap_reg) begin
                    st_next    = STAT_TOO_SMALL;
                    state_next = FS_STATUS;
                end else begin
                    st_next    = STAT_OK;
                    left_next  = chk_start;
                    state_next = FS_EMIT;
                end
            end

            FS_EMIT: begin
                if (left_reg != '0) begin
                    win_ctrl.rd_en = 1'b1;
                    emode_next     = 1'b1;
                    state_next     = FS_READ;
                end else begin
                    state_next = FS_STATUS;
                end
            end

            FS_READ: begin
                state_next = FS_OUT;
            end

            FS_OUT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.out_byte    = win_rd_data;
                    m_data_next.is_data     = 1'b1;
                    m_data_next.status      = STAT_OK;
                    m_data_next.out_length  = '0;
                    m_data_next.out_last    = 1'b0;
                    win_ctrl.pop            = 1'b1;
                    if (emode_reg) begin
                        left_next  = left_reg - CW'(1);
                        state_next = FS_EMIT;
                    end else begin
                        state_next = FS_DRAIN;
                    end
                end
            end

            // Close the message: drop anything still held, restart counts
            FS_STATUS: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.out_byte    = 8'd0;
                    m_data_next.is_data     = 1'b0;
                    m_data_next.status      = st_reg;
                    m_data_next.out_length  = len_reg;
                    m_data_next.out_last    = 1'b1;
                    win_ctrl.clear          = 1'b1;
                    phase_next              = '0;
                    total_next              = '0;
                    state_next              = FS_IDLE;
                end
            end

            default: begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FS_IDLE;
            phase_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            blk_reg     <= BLK_RESET;
            cap_reg     <= '1;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_BLOCK_BYTES:  blk_reg <= cfg_wdata[BLK_W-1:0];
                    CFG_OUT_CAPACITY: cap_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        ovf_reg    <= ovf_next;
        phz_reg    <= phz_next;
        emode_reg  <= emode_next;
        chk_reg    <= chk_next;
        left_reg   <= left_next;
        st_reg     <= st_next;
        len_reg    <= len_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == FS_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/pk7u_checker.sv =====
// ----------------------------------------------------------------------------
// pk7u_checker
// Port-level checks on the padding checker, bound to the top level.
// ----------------------------------------------------------------------------
module pk7u_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input pk7u_pkg::in_t   s_data,
    input logic            m_valid,
    input logic            m_ready,
    input pk7u_pkg::out_t  m_data
);
    import pk7u_pkg::*;

    // Hold a stalled result transaction unchanged
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Hold a waiting input transaction unchanged
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while waiting");

    // Not ready in the cycle after taking a byte
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // Come out of reset empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // A data transaction never closes a message
    a_data_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_data |-> !m_data.out_last && m_data.status == STAT_OK)
        else $error("data transaction carries status");

endmodule

bind pkcs7_unpad_checker_core pk7u_checker u_pk7u_checker (.*);

// ===== verif/pkcs7_unpad_checker_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7_unpad_checker_core_tb
// Self-checking bench for the streaming padding checker. A directed set of
// short messages covers the awkward block sizes, every status and a block
// size change in the middle of a message. Random phases then follow, mostly
// well-formed messages with some corrupted ones and noise, under several
// block sizes, capacities and idle patterns. Each accepted byte updates a
// local model of the window, and every result transaction is compared field
// by field with the oldest result that the model says is due.
// ----------------------------------------------------------------------------
module pkcs7_unpad_checker_core_tb;

    import pk7u_pkg::*;

    localparam int          MAX_BLK     = 32;
    localparam int          SETTLE_CYC  = 24;         // covers a byte that emits nothing
    localparam int          TAIL_CYC    = 200;
    localparam longint      WATCHDOG_NS = 8_000_000;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CAP_W-1:0]     cfg_wdata = '0;

    pkcs7_unpad_checker_core #(
        .MAX_BLOCK (MAX_BLK)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    in_t         byte_feed_q[$];     // bytes waiting to be offered to the block
    out_t        out_due_q[$];       // results the block still owes, oldest first
    int unsigned n_queued       = 0;
    int unsigned n_taken        = 0;
    int unsigned n_errors       = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        in_taken       = 1'b0;  // input transaction seen at the last rising edge

    // Model of the block: window of held bytes, block phase, message length
    // and the two registers
    logic [7:0]  held_q[$];
    int unsigned blk_phase = 0;
    logic [31:0] msg_len   = '0;
    logic [5:0]  blk_reg   = BLK_RESET;
    logic [31:0] cap_reg   = '1;

    // ------------------------------------------------------------------------
    // Unpadding model
    // ------------------------------------------------------------------------
    // Out-of-range register values clamp: zero acts as one, anything above
    // the window depth acts as the window depth.
    function automatic int unsigned blk_size(logic [5:0] v);
        if (v == 0) return 1;
        if (v > MAX_BLK) return MAX_BLK;
        return 32'(v);
    endfunction

    function automatic void put_data(logic [7:0] v);
        out_t r;
        r            = '0;
        r.out_byte   = v;
        r.is_data    = 1'b1;
        out_due_q.push_back(r);
    endfunction

    function automatic void put_status(logic [1:0] st, logic [31:0] len);
        out_t r;
        r            = '0;
        r.status     = st;
        r.out_length = len;
        r.out_last   = 1'b1;
        out_due_q.push_back(r);
    endfunction

    function automatic void end_message();
        held_q.delete();
        blk_phase = 0;
        msg_len   = '0;
    endfunction

    // Work out the results that one accepted byte causes
    function automatic void unpad_step(in_t it);
        int unsigned b, keep, ph, pad, fin, i;
        logic [31:0] unpadded;
        logic [1:0]  st;
        logic        sat;
        b    = blk_size(blk_reg);
        keep = b - 1;
        sat  = (msg_len == 32'hFFFF_FFFF);
        if (!sat) msg_len++;
        ph = (blk_phase + 1 >= b) ? 0 : blk_phase + 1;

        // Not the last byte: hold it, release whatever falls out of the window
        if (!it.in_last) begin
            blk_phase = ph;
            if (held_q.size() < MAX_BLK) held_q.push_back(it.in_byte);
            while (held_q.size() > keep) put_data(held_q.pop_front());
            return;
        end

        // A shrunken window releases its surplus before the final check
        while (held_q.size() > keep) put_data(held_q.pop_front());

        // Saturated length: report too small and skip every other check
        if (sat) begin
            put_status(STAT_TOO_SMALL, '1);
            end_message();
            return;
        end

        held_q.push_back(it.in_byte);
        fin      = held_q.size();
        pad      = 32'(it.in_byte);
        st       = STAT_OK;
        unpadded = '0;
        if (ph != 0 || pad == 0 || pad > b || pad > fin) begin
            st = STAT_BAD_PAD;
        end else begin
            for (i = fin - pad; i < fin; i++)
                if (held_q[i] != 8'(pad)) st = STAT_BAD_PAD;
        end
        if (st == STAT_OK) begin
            unpadded = msg_len - 32'(pad);
            if (unpadded > cap_reg) st = STAT_TOO_SMALL;
        end
        // Only a clean message releases its remaining payload
        if (st == STAT_OK) begin
            for (i = 0; i < fin - pad; i++) put_data(held_q[i]);
        end
        put_status(st, (st == STAT_BAD_PAD) ? 32'd0 : unpadded);
        end_message();
    endfunction

    function automatic void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t ns: %s expected %0h, got %0h", $time, fname, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        // Hold the current transaction until the block has taken it; then
        // either offer the next byte or leave the input idle.
        if (aresetn && (!s_valid || in_taken)) begin
            if (byte_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= byte_feed_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        // Stall the result channel at random, never while in reset
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge, advance the model, check results
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        out_t want;
        if (!aresetn) begin
            end_message();
            blk_reg  = BLK_RESET;
            cap_reg  = '1;
            in_taken <= 1'b0;
        end else begin
            // Register writes only happen while the block is idle
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_BLOCK_BYTES:  blk_reg = cfg_wdata[BLK_W-1:0];
                    CFG_OUT_CAPACITY: cap_reg = cfg_wdata;
                    default: ;
                endcase
            end
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                n_taken++;
                unpad_step(s_data);
            end
            if (m_valid && m_ready) begin
                if (out_due_q.size() == 0) begin
                    n_errors++;
                    $display({"%0t ns: expected no result, got byte %0h data %0b",
                              " status %0d len %0h last %0b"},
                             $time, m_data.out_byte, m_data.is_data, m_data.status,
                             m_data.out_length, m_data.out_last);
                end else begin
                    want = out_due_q.pop_front();
                    cmp_field("out_byte",   32'(want.out_byte),   32'(m_data.out_byte));
                    cmp_field("is_data",    32'(want.is_data),    32'(m_data.is_data));
                    cmp_field("status",     32'(want.status),     32'(m_data.status));
                    cmp_field("out_length", want.out_length,      m_data.out_length);
                    cmp_field("out_last",   32'(want.out_last),   32'(m_data.out_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_byte(logic [7:0] v, logic is_last);
        in_t it;
        it.in_byte = v;
        it.in_last = is_last;
        byte_feed_q.push_back(it);
        n_queued++;
    endfunction

    // Build one message for block size b and queue it; return its length.
    // Most are well formed; the rest carry a damaged pad byte, a wrong
    // length, a pad value of zero or above the block size, or pure noise.
    function automatic int unsigned queue_message(int unsigned b);
        logic [7:0]  body[$];
        int unsigned kind, dlen, pad, idx, k;
        kind = $urandom_range(99);
        if (kind >= 90) begin
            dlen = $urandom_range(1, 2 * b + 1);
            repeat (dlen) body.push_back(8'($urandom));
        end else begin
            dlen = $urandom_range(0, 2 * b);
            pad  = b - (dlen % b);
            repeat (dlen) body.push_back(8'($urandom));
            repeat (pad) body.push_back(8'(pad));
            if (kind >= 70 && kind < 78) begin
                if (pad >= 2) begin
                    idx       = $urandom_range(body.size() - pad, body.size() - 2);
                    body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
                end else begin
                    body.push_front(8'($urandom));
                end
            end else if (kind >= 78 && kind < 84) begin
                if ($urandom_range(1) == 1 && body.size() > 1) void'(body.pop_front());
                else body.push_front(8'($urandom));
            end else if (kind >= 84) begin
                body[body.size() - 1] = ($urandom_range(1) == 1) ? 8'h00
                                        : 8'($urandom_range(b + 1, 255));
            end
        end
        for (k = 0; k < body.size(); k++) queue_byte(body[k], k == body.size() - 1);
        return body.size();
    endfunction

    // Hold off until every byte is taken and every result has arrived, then
    // let the block finish any byte that owes no result
    task automatic wait_quiet();
        while (n_taken != n_queued || out_due_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One random phase: drain, set both registers and the idle pattern, then
    // queue messages. Sometimes leave a message open so that the next phase
    // changes the block size under it.
    task automatic run_phase(logic [5:0] blk, logic [31:0] cap, int unsigned s_idle,
                             int unsigned r_stall, int unsigned n_items);
        int unsigned eb, cnt;
        wait_quiet();
        cfg_write(CFG_BLOCK_BYTES, {26'($urandom), blk});
        cfg_write(CFG_OUT_CAPACITY, cap);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        eb  = blk_size(blk);
        cnt = 0;
        while (cnt < n_items) cnt += queue_message(eb);
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset setting, 16-byte blocks: a lone final byte is never a block
        queue_byte(8'h10, 1'b1);
        wait_quiet();

        // Block size zero acts as one; upper write bits are ignored; no room
        cfg_write(CFG_BLOCK_BYTES, {26'h3FF_FFFF, 6'd0});
        cfg_write(CFG_OUT_CAPACITY, 32'd0);
        queue_byte(8'h01, 1'b1);                   // padding only: empty payload fits
        queue_byte(8'hFF, 1'b0);                   // streamed at once, then too small
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h00, 1'b1);                   // pad value zero
        queue_byte(8'h02, 1'b1);                   // pad value above the block size
        wait_quiet();

        cfg_write(CFG_BLOCK_BYTES, 32'd4);
        cfg_write(CFG_OUT_CAPACITY, 32'hFFFF_FFFF);
        queue_byte(8'h00, 1'b0);                   // clean, extreme payload values
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h02, 1'b1);
        queue_byte(8'hAA, 1'b0);                   // pad bytes disagree
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h04, 1'b0);
        queue_byte(8'h03, 1'b1);
        queue_byte(8'h11, 1'b0);                   // length not a whole block
        queue_byte(8'h22, 1'b0);
        queue_byte(8'h33, 1'b1);
        // Open a message, then shrink the window under it
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h02, 1'b0);
        wait_quiet();
        cfg_write(CFG_BLOCK_BYTES, 32'd2);
        queue_byte(8'h02, 1'b1);
        // Open a message, then grow the window under it
        queue_byte(8'h05, 1'b0);
        wait_quiet();
        cfg_write(CFG_BLOCK_BYTES, 32'd4);
        queue_byte(8'h06, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h02, 1'b1);
        wait_quiet();

        // Capacity one below the payload
        cfg_write(CFG_OUT_CAPACITY, 32'd1);
        queue_byte(8'h07, 1'b0);
        queue_byte(8'h08, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h02, 1'b1);

        // Random phases: block sizes including both clamps, assorted capacities
        run_phase(6'd16, 32'hFFFF_FFFF,           0,  0, 35);
        run_phase(6'd8,  $urandom_range(0, 24),   52, 0, 35);
        run_phase(6'd63, 32'hFFFF_FFFF,           0, 52, 35);
        run_phase(6'd3,  $urandom,                35, 35, 30);
        run_phase(6'd0,  32'd1,                   0,  0, 20);
        run_phase(6'd33, 32'd40,                  52, 0, 30);
        run_phase(6'd5,  32'd12,                  0, 52, 30);
        run_phase(6'd2,  32'hFFFF_FFFF,           35, 35, 25);

        // Drain, then allow for any stray result
        wait_quiet();
        repeat (TAIL_CYC) @(posedge aclk);
        if (out_due_q.size() != 0) begin
            n_errors += out_due_q.size();
            $display("%0t ns: %0d results expected, none arrived", $time, out_due_q.size());
        end
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #(WATCHDOG_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
